FILE: hw/rtl/powq_pkg.sv
// shared constants, codes and structs for the priority ordered wait queue
// used by powq_cell and priority_ordered_wait_queue; no dependencies
`timescale 1ns / 1ps

package powq_pkg;

    localparam int CAPACITY  = 16;
    localparam int ID_BITS   = 8;
    localparam int PRIO_BITS = 5;
    localparam int COUNT_W   = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int TASK_ID_W = 8;
    localparam int TASK_PRIO_W = 5;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

    // command broadcast to every cell
    typedef struct packed {
        logic                 do_ins;
        logic                 do_del;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                 valid;
        logic                 le;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
    } slot_t;

endpackage

FILE: hw/rtl/powq_cell.sv
// one slot of the sorted queue: holds id, priority and valid bit
// depends on powq_pkg
`timescale 1ns / 1ps

module powq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  powq_pkg::cmd_t       cmd,
    input  powq_pkg::slot_t      left,
    input  powq_pkg::slot_t      right,
    input  logic                 kill_in,
    output logic                 kill_out,
    output logic                 match,
    output powq_pkg::slot_t      slot
);

    logic                           valid_reg, valid_next;
    logic [powq_pkg::ID_BITS-1:0]   id_reg, id_next;
    logic [powq_pkg::PRIO_BITS-1:0] prio_reg, prio_next;

    assign match      = valid_reg && (id_reg == cmd.id);
    assign kill_out   = kill_in || match;
    assign slot.valid = valid_reg;
    assign slot.le    = valid_reg && (prio_reg <= cmd.prio);
    assign slot.id    = id_reg;
    assign slot.prio  = prio_reg;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (cmd.do_ins && !slot.le)
        begin
            if (left.le)
            begin
                // new entry lands here
                valid_next = 1'b1;
                id_next    = cmd.id;
                prio_next  = cmd.prio;
            end
            else
            begin
                valid_next = left.valid;
                id_next    = left.id;
                prio_next  = left.prio;
            end
        end
        else if (cmd.do_del && kill_out)
        begin
            valid_next = right.valid;
            id_next    = right.id;
            prio_next  = right.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

FILE: hw/rtl/priority_ordered_wait_queue.sv
// top level of the priority ordered wait queue: a chain of powq_cell slots
// depends on powq_pkg and powq_cell
`timescale 1ns / 1ps

// usage
// - input channel in_valid / in_ready carries one operation per beat:
//   operation (insert, pop front, remove by id), task_id, task_priority
// - output channel out_valid / out_ready returns one result beat per
//   input beat: result_id, status and occupancy after the operation
// - the queue is a row of cells sorted by ascending priority value; every
//   cell compares itself against the broadcast command and takes its own,
//   the new entry, or its left or right neighbor's entry in the same cycle
// - the result is registered on taking the beat, shown in the next cycle
// - throughput: one operation per cycle while out_ready is high, as all
//   cells update together with the duplicate / match reduction over them
// - a stalled receiver holds the result register; a new beat is taken in
//   the same cycle that the waiting result is taken
// - reset empties the queue at once (valid bits only), no clearing pass
// - an insert of an id already present leaves the queue unchanged

module priority_ordered_wait_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [powq_pkg::OP_W-1:0]        operation,
    input  logic [powq_pkg::TASK_ID_W-1:0]   task_id,
    input  logic [powq_pkg::TASK_PRIO_W-1:0] task_priority,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [powq_pkg::TASK_ID_W-1:0]   result_id,
    output logic [powq_pkg::STATUS_W-1:0]    status,
    output logic [powq_pkg::OCC_W-1:0]       occupancy
);

    localparam int N = powq_pkg::CAPACITY;

    logic                          in_fire;
    logic [powq_pkg::ID_BITS-1:0]  id_in;
    powq_pkg::cmd_t                cmd;
    powq_pkg::slot_t               slots [N];
    powq_pkg::slot_t               left_of [N];
    powq_pkg::slot_t               right_of [N];
    logic [N:0]                    kill_chain;
    logic [N-1:0]                  match_vec;
    logic [N-1:0]                  valid_vec;
    logic                          any_match;
    logic                          full;
    logic                          nonempty;

    logic [powq_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          out_valid_reg;
    logic [powq_pkg::ID_BITS-1:0]  rid_reg, rid_next;
    logic [powq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          ins_ok, del_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    // the low ID_BITS bits of the identifier take part, here all of them
    assign id_in    = task_id[powq_pkg::ID_BITS-1:0];

    assign any_match = |match_vec;
    assign full      = valid_vec[N-1];
    assign nonempty  = valid_vec[0];

    // result and action decode
    always_comb
    begin
        rid_next    = '0;
        status_next = powq_pkg::ST_NONE;
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        count_next  = count_reg;
        unique case (operation)
            powq_pkg::OP_INSERT:
            begin
                priority if (any_match)
                begin
                    status_next = powq_pkg::ST_PRESENT;
                end
                else if (full)
                begin
                    status_next = powq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = powq_pkg::ST_OK;
                    ins_ok      = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            powq_pkg::OP_POP:
            begin
                if (nonempty)
                begin
                    rid_next    = slots[0].id;
                    status_next = powq_pkg::ST_OK;
                    del_ok      = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            powq_pkg::OP_REMOVE:
            begin
                if (any_match)
                begin
                    // the matching cell holds exactly the requested id
                    rid_next    = id_in;
                    status_next = powq_pkg::ST_OK;
                    del_ok      = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = powq_pkg::ST_NONE;
            end
        endcase
    end

    assign cmd.do_ins = in_fire && ins_ok;
    assign cmd.do_del = in_fire && del_ok;
    assign cmd.id     = id_in;
    assign cmd.prio   = task_priority[powq_pkg::PRIO_BITS-1:0];

    // a pop clears the front cell and every cell behind it shifts forward
    assign kill_chain[0] = (operation == powq_pkg::OP_POP);

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                // the virtual slot ahead of the front always sorts first
                assign left_of[g] = '{valid: 1'b1, le: 1'b1, id: '0, prio: '0};
            end
            else
            begin : g_mid
                assign left_of[g] = slots[g-1];
            end
            if (g == N - 1)
            begin : g_tail
                assign right_of[g] = '{valid: 1'b0, le: 1'b0, id: '0, prio: '0};
            end
            else
            begin : g_body
                assign right_of[g] = slots[g+1];
            end

            powq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .left     (left_of[g]),
                .right    (right_of[g]),
                .kill_in  (kill_chain[g]),
                .kill_out (kill_chain[g+1]),
                .match    (match_vec[g]),
                .slot     (slots[g])
            );

            assign valid_vec[g] = slots[g].valid;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rid_reg    <= rid_next;
            status_reg <= status_next;
        end
    end

    // occupancy after the beat equals the count held now
    logic [powq_pkg::COUNT_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            occ_reg <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_id = powq_pkg::TASK_ID_W'(rid_reg);
    assign status    = status_reg;
    assign occupancy = powq_pkg::OCC_W'(occ_reg);

    // count tracks the number of occupied cells
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("count does not match occupied cells");

    // occupied cells always form a prefix of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("hole in occupied cells");

    // an accepted insert adds exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the queue");

    // an insert and a delete never happen together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_ins && cmd.do_del))
        else $error("insert and delete at once");

endmodule

FILE: dv/tb_top.sv
// self-checking bench for priority_ordered_wait_queue: random and directed
// operations, an in-bench sorted queue predicts each result beat
// depends on powq_pkg and the priority_ordered_wait_queue rtl
`timescale 1ns / 1ps

module tb_top;

    // the unused operation code, not in the package
    localparam logic [powq_pkg::OP_W-1:0] OP_NOP = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 18;
    localparam int ID_POOL      = 24;   // small id range so duplicates and removes hit
    localparam int HOLD_AT      = 120;  // result count that starts the long receiver stall
    localparam int HOLD_CYCLES  = 60;
    localparam int CALM_FROM    = 320;  // accepted-beat window with no idling
    localparam int CALM_TO      = 440;
    localparam int TAIL_CYCLES  = 4;

    typedef struct {
        logic                             pause;  // sender waits here until all results are in
        logic [powq_pkg::OP_W-1:0]        op;
        logic [powq_pkg::TASK_ID_W-1:0]   id;
        logic [powq_pkg::TASK_PRIO_W-1:0] prio;
    } op_beat_t;

    typedef struct {
        logic [powq_pkg::TASK_ID_W-1:0] id;
        logic [powq_pkg::STATUS_W-1:0]  status;
        logic [powq_pkg::OCC_W-1:0]     occ;
    } result_beat_t;

    // ---------------------------------------------------------------
    // clock, reset and dut
    // ---------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [powq_pkg::OP_W-1:0]        operation = powq_pkg::OP_INSERT;
    logic [powq_pkg::TASK_ID_W-1:0]   task_id = '0;
    logic [powq_pkg::TASK_PRIO_W-1:0] task_priority = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [powq_pkg::TASK_ID_W-1:0]   result_id;
    logic [powq_pkg::STATUS_W-1:0]    status;
    logic [powq_pkg::OCC_W-1:0]       occupancy;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // reset held low from the start, released away from the rising edge
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    priority_ordered_wait_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .task_id       (task_id),
        .task_priority (task_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_id     (result_id),
        .status        (status),
        .occupancy     (occupancy)
    );

    // ---------------------------------------------------------------
    // bookkeeping
    // ---------------------------------------------------------------
    op_beat_t     pending_ops[$];
    result_beat_t expected_results[$];
    int           n_accepted = 0;
    int           n_results = 0;
    int           n_errors = 0;
    int           cycle_count = 0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;
    logic         calm;

    // a stretch of the run in which neither side idles
    assign calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

    // ---------------------------------------------------------------
    // sorted wait queue predictor
    // slots 0 .. wq_count-1 hold entries, front at slot 0
    // ---------------------------------------------------------------
    logic [powq_pkg::ID_BITS-1:0]   wq_ids  [powq_pkg::CAPACITY];
    logic [powq_pkg::PRIO_BITS-1:0] wq_prios[powq_pkg::CAPACITY];
    int                             wq_count = 0;

    function automatic int find_waiting(logic [powq_pkg::ID_BITS-1:0] id);
        for (int i = 0; i < wq_count; i++)
            if (wq_ids[i] == id)
                return i;
        return -1;
    endfunction

    // shift the tail left over the slot being taken out
    function automatic void close_gap(int pos);
        for (int i = pos; i + 1 < wq_count; i++)
        begin
            wq_ids[i]   = wq_ids[i + 1];
            wq_prios[i] = wq_prios[i + 1];
        end
        wq_count--;
    endfunction

    function automatic void apply_wait_op(op_beat_t b);
        result_beat_t                   r;
        int                             pos;
        logic [powq_pkg::ID_BITS-1:0]   bid;
        logic [powq_pkg::PRIO_BITS-1:0] bprio;
        bid      = b.id[powq_pkg::ID_BITS-1:0];
        bprio    = b.prio[powq_pkg::PRIO_BITS-1:0];
        r.id     = '0;
        r.status = powq_pkg::ST_NONE;
        case (b.op)
            powq_pkg::OP_INSERT:
            begin
                // duplicate check wins over the full check
                if (find_waiting(bid) >= 0)
                begin
                    r.status = powq_pkg::ST_PRESENT;
                end
                else if (wq_count >= powq_pkg::CAPACITY)
                begin
                    r.status = powq_pkg::ST_FULL;
                end
                else
                begin
                    // behind every entry of equal or lower value: ties stay in order
                    pos = 0;
                    while (pos < wq_count && wq_prios[pos] <= bprio)
                        pos++;
                    for (int i = wq_count; i > pos; i--)
                    begin
                        wq_ids[i]   = wq_ids[i - 1];
                        wq_prios[i] = wq_prios[i - 1];
                    end
                    wq_ids[pos]   = bid;
                    wq_prios[pos] = bprio;
                    wq_count++;
                    r.status = powq_pkg::ST_OK;
                end
            end
            powq_pkg::OP_POP:
            begin
                if (wq_count > 0)
                begin
                    r.id = powq_pkg::TASK_ID_W'(wq_ids[0]);
                    close_gap(0);
                    r.status = powq_pkg::ST_OK;
                end
            end
            powq_pkg::OP_REMOVE:
            begin
                pos = find_waiting(bid);
                if (pos >= 0)
                begin
                    r.id = powq_pkg::TASK_ID_W'(wq_ids[pos]);
                    close_gap(pos);
                    r.status = powq_pkg::ST_OK;
                end
            end
            default: ;  // unused code: no change, empty status
        endcase
        r.occ = powq_pkg::OCC_W'(wq_count);
        expected_results.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // driver: offers beats from pending_ops, holds each until taken
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        op_beat_t nxt;
        logic     next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                nxt.pause = 1'b0;
                nxt.op    = operation;
                nxt.id    = task_id;
                nxt.prio  = task_priority;
                apply_wait_op(nxt);
                n_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_ops.size() != 0)
            begin
                if (pending_ops[0].pause)
                begin
                    // sender pause: nothing more until every result is back
                    if (expected_results.size() == 0)
                        void'(pending_ops.pop_front());
                end
                else if (calm || $urandom_range(0, 99) >= IDLE_PCT)
                begin
                    nxt = pending_ops.pop_front();
                    operation     <= nxt.op;
                    task_id       <= nxt.id;
                    task_priority <= nxt.prio;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // ---------------------------------------------------------------
    // long receiver stall, counted here so the sender keeps offering
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_results >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // monitor: each result beat against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t exp_r;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: id %0d status %0d occ %0d",
                           result_id, status, occupancy);
                    n_errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result_id !== exp_r.id)
                    begin
                        $error("result_id: expected %0d, got %0d", exp_r.id, result_id);
                        n_errors++;
                    end
                    if (status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, status);
                        n_errors++;
                    end
                    if (occupancy !== exp_r.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", exp_r.occ, occupancy);
                        n_errors++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic void add_op(logic [powq_pkg::OP_W-1:0] op,
                                   logic [powq_pkg::TASK_ID_W-1:0] id,
                                   logic [powq_pkg::TASK_PRIO_W-1:0] prio);
        op_beat_t b;
        b.pause = 1'b0;
        b.op    = op;
        b.id    = id;
        b.prio  = prio;
        pending_ops.push_back(b);
    endfunction

    function automatic void add_pause();
        op_beat_t b;
        b.pause = 1'b1;
        b.op    = OP_NOP;
        b.id    = '0;
        b.prio  = '0;
        pending_ops.push_back(b);
    endfunction

    // mostly a small pool so ids collide, sometimes the full range
    function automatic logic [powq_pkg::TASK_ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 70)
            return powq_pkg::TASK_ID_W'($urandom_range(0, ID_POOL - 1));
        return powq_pkg::TASK_ID_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int ins_pct;
        int roll;
        logic [powq_pkg::TASK_PRIO_W-1:0] prio;

        // directed: empty queue cases and the unused code
        add_op(powq_pkg::OP_POP,    8'd0,   5'd0);
        add_op(powq_pkg::OP_REMOVE, 8'd255, 5'd31);
        add_op(OP_NOP,              8'd255, 5'd31);
        // extremes, a tie at the highest value, then a duplicate
        add_op(powq_pkg::OP_INSERT, 8'd0,   5'd0);
        add_op(powq_pkg::OP_INSERT, 8'd255, 5'd31);
        add_op(powq_pkg::OP_INSERT, 8'd7,   5'd31);
        add_op(powq_pkg::OP_INSERT, 8'd255, 5'd3);
        // remove from the middle, then pop the rest in order
        add_op(powq_pkg::OP_REMOVE, 8'd255, 5'd0);
        add_op(powq_pkg::OP_POP,    8'd0,   5'd0);
        add_op(powq_pkg::OP_POP,    8'd0,   5'd0);
        // fill to capacity with few priorities, then full and duplicate-on-full
        for (int i = 0; i < powq_pkg::CAPACITY; i++)
            add_op(powq_pkg::OP_INSERT, powq_pkg::TASK_ID_W'(8'd100 + i),
                   powq_pkg::TASK_PRIO_W'((i * 7) % 4));
        add_op(powq_pkg::OP_INSERT, 8'd200, 5'd0);
        add_op(powq_pkg::OP_INSERT, 8'd100, 5'd0);
        add_pause();

        // random: blocks with different insert bias walk the fill level
        for (int blk = 0; blk < 13; blk++)
        begin
            ins_pct = (blk % 3 == 0) ? 80 : ((blk % 3 == 1) ? 25 : 50);
            for (int k = 0; k < 50; k++)
            begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 70)
                    prio = powq_pkg::TASK_PRIO_W'($urandom_range(0, 3));
                else
                    prio = powq_pkg::TASK_PRIO_W'($urandom_range(0, 31));
                if (roll < ins_pct)
                begin
                    add_op(powq_pkg::OP_INSERT, pick_id(), prio);
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60)
                        add_op(powq_pkg::OP_POP,
                               powq_pkg::TASK_ID_W'($urandom_range(0, 255)), prio);
                    else if (roll < 95)
                        add_op(powq_pkg::OP_REMOVE, pick_id(), prio);
                    else
                        add_op(OP_NOP, powq_pkg::TASK_ID_W'($urandom_range(0, 255)), prio);
                end
            end
            if (blk % 4 == 3)
                add_pause();
        end

        // drain and settle
        wait (rst_n === 1'b1);
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------
    // run limit
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
